// ----- rtl/nearest_point_deviation_stats_unit_macros.svh -----
// Assertion macros shared by the checker
`ifndef NEAREST_POINT_DEVIATION_STATS_UNIT_MACROS_SVH
`define NEAREST_POINT_DEVIATION_STATS_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define NPDS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("npds check failed");

// Next-cycle implication checked outside reset
`define NPDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("npds check failed");

`endif

// ----- rtl/npds_pkg.sv -----
`timescale 1ns / 1ps
package npds_pkg;

  localparam int unsigned RefDepth  = 4096;
  localparam int unsigned CoordBits = 24;
  localparam int unsigned AddrBits  = $clog2(RefDepth);
  localparam int unsigned CntBits   = AddrBits + 1;
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned SqBits    = 2 * DiffBits;
  localparam int unsigned D2Bits    = SqBits + 2;
  localparam int unsigned DevBits   = 26;
  localparam int unsigned StatBits  = 20;
  localparam int unsigned SumBits   = 46;
  localparam int unsigned TolBits   = 26;
  localparam int unsigned RootBits  = (D2Bits + 1) / 2;

  localparam logic [DevBits-1:0]  DevMax = '1;
  localparam logic [StatBits-1:0] CntMax = '1;
  localparam logic [SumBits-1:0]  SumMax = '1;
  localparam logic [TolBits-1:0]  TolReset = TolBits'(512);

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_REFS = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]                  func;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] pz;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [DevBits-1:0]  deviation;
    logic                over_tolerance;
    logic [12:0]         reference_count;
    logic [StatBits-1:0] measured_count;
    logic [StatBits-1:0] over_count;
    logic [DevBits-1:0]  max_deviation;
    logic [SumBits-1:0]  deviation_sum;
  } out_item_t;

  // Classified command passed from front to back
  typedef struct packed {
    func_e                       op;
    logic signed [CoordBits-1:0] px;
    logic signed [CoordBits-1:0] py;
    logic signed [CoordBits-1:0] pz;
  } cmd_t;

endpackage

// ----- rtl/npds_front.sv -----
`timescale 1ns / 1ps
module npds_front import npds_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  in_item_t in_item_i,
  output logic     cmd_valid_o,
  input  logic     cmd_take_i,
  output cmd_t     cmd_o
);

  localparam int unsigned Depth = 2;

  cmd_t     fifo_q [Depth];
  logic     wp_q, rp_q;
  logic [1:0] cnt_q;
  logic     wr, rd;
  func_e    op;

  // classify the func code; all four codes map onto func_e
  assign op = func_e'(in_item_i.func);

  assign full        = (cnt_q == 2'(Depth));
  assign wr          = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign rd          = cmd_valid_o && cmd_take_i;
  assign cmd_o       = fifo_q[rp_q];

  // small command queue
  always_ff @(posedge clk_i) begin
    if (wr) fifo_q[wp_q] <= '{op: op, px: in_item_i.px, py: in_item_i.py, pz: in_item_i.pz};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr) - 2'(rd);
    end
  end

endmodule

// ----- rtl/npds_sqrt.sv -----
`timescale 1ns / 1ps
module npds_sqrt import npds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [D2Bits-1:0] radicand_i,
  output logic              done_o,
  output logic [RootBits-1:0] root_o
);

  localparam int unsigned RemBits = RootBits + 2;
  localparam int unsigned StepBits = $clog2(RootBits + 1);

  logic [2*RootBits-1:0] n_q, n_d;
  logic [RemBits-1:0]    rem_q, rem_d;
  logic [RootBits-1:0]   root_q, root_d;
  logic [StepBits-1:0]   step_q, step_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [RemBits-1:0]    trial, remsh;

  // one result bit per cycle, restoring method
  always_comb begin
    n_d = n_q; rem_d = rem_q; root_d = root_q; step_d = step_q;
    busy_d = busy_q; done_d = 1'b0;
    remsh = {rem_q[RemBits-3:0], n_q[2*RootBits-1 -: 2]};
    trial = {root_q, 2'b01};
    if (start_i) begin
      n_d = (2*RootBits)'(radicand_i);
      rem_d = '0; root_d = '0; step_d = StepBits'(RootBits); busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[2*RootBits-3:0], 2'b00};
      if (remsh >= trial) begin
        rem_d = remsh - trial;
        root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d = remsh;
        root_d = {root_q[RootBits-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepBits'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; rem_q <= rem_d; root_q <= root_d; step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- rtl/npds_back.sv -----
`timescale 1ns / 1ps
module npds_back import npds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_take_o,
  input  cmd_t               cmd_i,
  input  logic [TolBits-1:0] tol_i,
  output logic               res_valid_o,
  input  logic               res_take_i,
  output out_item_t          res_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_DIST  = 6'b000100,
    S_ROOT  = 6'b001000,
    S_STATS = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q;

  logic [3*CoordBits-1:0] mem [RefDepth];
  logic [3*CoordBits-1:0] rd_q;
  logic [AddrBits-1:0]    addr_q;
  logic [CntBits-1:0]     ref_cnt_q;
  logic [StatBits-1:0]    meas_q, over_q;
  logic [DevBits-1:0]     maxd_q, dev_q;
  logic [SumBits-1:0]     sum_q;
  cmd_t                   cmd_q;
  out_item_t              res_q;

  // scan pipeline: read, square, sum, compare
  logic                   rv_q, sv_q, dv_q;
  logic [SqBits-1:0]      sx_q, sy_q, sz_q;
  logic [D2Bits-1:0]      d2_q, best_q;
  logic signed [DiffBits-1:0] dx, dy, dz;
  logic [DiffBits-1:0]    ax, ay, az;
  logic [CntBits-1:0]     issued_q;
  logic                   issuing;

  logic                   sq_start, sq_done;
  logic [RootBits-1:0]    root;
  logic [DevBits-1:0]     dev_sat;
  logic                   over_bit;
  logic [SumBits:0]       sum_wide;

  assign cmd_take_o = (state_q == S_IDLE) && !res_valid_o;
  assign issuing = (state_q == S_SCAN) && (issued_q < ref_cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_take_o && cmd_valid_i && cmd_i.op == FUNC_LOAD && ref_cnt_q < CntBits'(RefDepth))
      mem[ref_cnt_q[AddrBits-1:0]] <= {cmd_i.px, cmd_i.py, cmd_i.pz};
    if (issuing) rd_q <= mem[addr_q];
  end

  assign dx = DiffBits'(cmd_q.px) - DiffBits'($signed(rd_q[3*CoordBits-1 -: CoordBits]));
  assign dy = DiffBits'(cmd_q.py) - DiffBits'($signed(rd_q[2*CoordBits-1 -: CoordBits]));
  assign dz = DiffBits'(cmd_q.pz) - DiffBits'($signed(rd_q[CoordBits-1:0]));
  assign ax = dx[DiffBits-1] ? DiffBits'(-dx) : DiffBits'(dx);
  assign ay = dy[DiffBits-1] ? DiffBits'(-dy) : DiffBits'(dy);
  assign az = dz[DiffBits-1] ? DiffBits'(-dz) : DiffBits'(dz);

  always_ff @(posedge clk_i) begin
    sx_q <= ax * ax;
    sy_q <= ay * ay;
    sz_q <= az * az;
    d2_q <= D2Bits'(sx_q) + D2Bits'(sy_q) + D2Bits'(sz_q);
  end

  assign sq_start = (state_q == S_DIST);
  npds_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i(best_q),
    .done_o(sq_done), .root_o(root)
  );

  assign dev_sat  = (root > RootBits'(DevMax)) ? DevMax : DevBits'(root);
  assign over_bit = dev_q > tol_i;
  assign sum_wide = (SumBits+1)'(sum_q) + (SumBits+1)'(dev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ref_cnt_q <= '0;
      meas_q    <= '0;
      over_q    <= '0;
      maxd_q    <= '0;
      sum_q     <= '0;
      res_valid_o <= 1'b0;
      rv_q <= 1'b0; sv_q <= 1'b0; dv_q <= 1'b0;
      issued_q <= '0;
      addr_q <= '0;
    end else begin
      if (res_valid_o && res_take_i) res_valid_o <= 1'b0;
      rv_q <= issuing;
      sv_q <= rv_q;
      dv_q <= sv_q;
      case (state_q)
        S_IDLE: begin
          if (cmd_take_o && cmd_valid_i) begin
            cmd_q <= cmd_i;
            res_q.deviation      <= '0;
            res_q.over_tolerance <= 1'b0;
            case (cmd_i.op)
              FUNC_CLEAR: begin
                ref_cnt_q <= '0; meas_q <= '0; over_q <= '0;
                maxd_q <= '0; sum_q <= '0;
                res_q.status <= ST_OK;
                state_q <= S_OUT;
              end
              FUNC_LOAD: begin
                if (ref_cnt_q >= CntBits'(RefDepth)) begin
                  res_q.status <= ST_FULL;
                end else begin
                  res_q.status <= ST_OK;
                  ref_cnt_q <= ref_cnt_q + 1'b1;
                end
                state_q <= S_OUT;
              end
              FUNC_QUERY: begin
                if (ref_cnt_q == '0) begin
                  dev_q <= DevMax;
                  res_q.status <= ST_NO_REFS;
                  state_q <= S_STATS;
                end else begin
                  res_q.status <= ST_OK;
                  best_q <= '1;
                  issued_q <= '0;
                  addr_q <= '0;
                  state_q <= S_SCAN;
                end
              end
              default: begin
                res_q.status <= ST_OK;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issuing) begin
            issued_q <= issued_q + 1'b1;
            addr_q <= addr_q + 1'b1;
          end
          if (dv_q && d2_q < best_q) best_q <= d2_q;
          if (!issuing && !rv_q && !sv_q && !dv_q) state_q <= S_DIST;
        end
        S_DIST: state_q <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            dev_q <= dev_sat;
            state_q <= S_STATS;
          end
        end
        S_STATS: begin
          res_q.deviation <= dev_q;
          res_q.over_tolerance <= over_bit;
          if (meas_q != CntMax) meas_q <= meas_q + 1'b1;
          if (over_bit && over_q != CntMax) over_q <= over_q + 1'b1;
          if (dev_q > maxd_q) maxd_q <= dev_q;
          sum_q <= sum_wide[SumBits] ? SumMax : sum_wide[SumBits-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          res_q.reference_count <= 13'(ref_cnt_q);
          res_q.measured_count  <= meas_q;
          res_q.over_count      <= over_q;
          res_q.max_deviation   <= maxd_q;
          res_q.deviation_sum   <= sum_q;
          res_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o = res_q;

endmodule

// ----- rtl/nearest_point_deviation_stats_unit.sv -----
`timescale 1ns / 1ps
// Channel   Handshake         Payload
// input     push / full       in_item_i  (func, px, py, pz)
// result    pop / empty       out_item_o (status .. deviation_sum)
// config    tol_we_i          tol_wdata_i (tolerance)
// An accepted item reaches the back end through the command queue, which registers it.
// Clear, load and unused codes go from S_IDLE through S_OUT to the result.
// A query scans the N stored references, one store read a cycle through a 4-stage
// distance pipeline, then takes a bit-serial square root of the nearest distance.
// An empty-store query skips the scan and goes to S_STATS and S_OUT. Reset is asynchronous, no sweep.
// A held result stops the back end; input stalls once the 2-entry queue fills.
module nearest_point_deviation_stats_unit import npds_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_item_t           in_item_i,
  output logic               empty,
  input  logic               pop,
  output out_item_t          out_item_o,
  input  logic               tol_we_i,
  input  logic [TolBits-1:0] tol_wdata_i
);

  logic [TolBits-1:0] tol_q;
  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;

  // tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tol_q <= TolReset;
    else if (tol_we_i) tol_q <= tol_wdata_i;
  end

  npds_front u_front (
    .clk_i, .rst_ni, .push, .full, .in_item_i,
    .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take), .cmd_o(cmd)
  );

  npds_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take), .cmd_i(cmd),
    .tol_i(tol_q), .res_valid_o(res_valid), .res_take_i(pop), .res_o(out_item_o)
  );

  assign empty = !res_valid;

endmodule

// ----- rtl/npds_checker.sv -----
`timescale 1ns / 1ps
`include "nearest_point_deviation_stats_unit_macros.svh"
module npds_checker import npds_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  `NPDS_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o))
  `NPDS_ASSERT_IMP(a_over_dev, clk_i, rst_ni, !empty && out_item_o.over_tolerance, out_item_o.deviation != '0)
  `NPDS_ASSERT_IMP(a_max_ge, clk_i, rst_ni, !empty, out_item_o.max_deviation >= out_item_o.deviation)
  `NPDS_ASSERT_IMP(a_cnt_ord, clk_i, rst_ni, !empty, out_item_o.over_count <= out_item_o.measured_count)

endmodule

bind nearest_point_deviation_stats_unit npds_checker u_npds_checker (
  .clk_i, .rst_ni, .empty, .pop, .out_item_o
);
